[hw/rtl/lav_pkg.sv]
// Shared types and fixed constants for the look-at view matrix pipeline.
`default_nettype none
package lav_pkg;

	// Coordinate word at the ports
	localparam int COORD_W = 32;
	typedef logic signed [COORD_W-1:0] coord_t;

	// Normalizer: largest scaled magnitude lands in [2^30, 2^31)
	localparam int NORM_MSB = 30;
	localparam int NORM_W   = 31;
	localparam int SUM_W    = 64;

	// Square root iteration count, and square root and divider steps per pipeline stage
	localparam int SQRT_ITERS     = 32;
	localparam int SQRT_PER_STAGE = 2;
	localparam int DIV_PER_STAGE  = 2;

endpackage
`default_nettype wire

[hw/rtl/lav_norm.sv]
// Pipelined 3-vector normalizer: scale, sum of squares, square root, divide.
`default_nettype none
module lav_norm
	import lav_pkg::*;
#(
	parameter int IW = 33,
	parameter int F  = 16,
	parameter int SW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic signed [IW-1:0] in_x,
	input  logic signed [IW-1:0] in_y,
	input  logic signed [IW-1:0] in_z,
	input  logic [SW-1:0]        in_side,
	output logic                 out_vld,
	output logic signed [F+1:0]  out_x,
	output logic signed [F+1:0]  out_y,
	output logic signed [F+1:0]  out_z,
	output logic [SW-1:0]        out_side
);

	localparam int PW  = $clog2(IW);
	localparam int RS  = SQRT_ITERS / SQRT_PER_STAGE;
	localparam int QB  = F + 1;
	localparam int DS  = (QB + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
	localparam int NW  = NORM_W + 1 + F;
	localparam int LAT = 7 + RS + DS;
	localparam int DW  = SW + 4;

	// two square-root iterations (bit-pair method), rem and root packed
	function automatic logic [2*SUM_W-1:0] sqrt_pair(input logic [SUM_W-1:0] rem,
		input logic [SUM_W-1:0] res, input int k);
		logic [SUM_W-1:0] x;
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] b;
		logic [SUM_W-1:0] t;
		x = rem;
		r = res;
		for (int j = 0; j < SQRT_PER_STAGE; j++) begin
			b = SUM_W'(1) << (SUM_W - 2 - 2 * (SQRT_PER_STAGE * k + j));
			t = r + b;
			if (x >= t) begin
				x = x - t;
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return {x, r};
	endfunction

	// restoring division steps, remainder and quotient packed
	function automatic logic [NW+QB-1:0] div_pair(input logic [NW-1:0] rem,
		input logic [QB-1:0] q, input logic [NORM_W:0] n, input int k);
		logic [NW-1:0] r;
		logic [NW-1:0] d;
		logic [QB-1:0] qq;
		int            b;
		r  = rem;
		qq = q;
		for (int j = 0; j < DIV_PER_STAGE; j++) begin
			b = QB - 1 - (DIV_PER_STAGE * k + j);
			if (b >= 0) begin
				d = NW'(n) << b;
				if (r >= d) begin
					r  = r - d;
					qq = qq | (QB'(1) << b);
				end
			end
		end
		return {r, qq};
	endfunction

	// cap at one, restore sign, force zero for a zero vector
	function automatic logic signed [F+1:0] finish(input logic [QB-1:0] q,
		input logic neg, input logic zero);
		logic [QB-1:0]      m;
		logic signed [F+1:0] v;
		m = (q > (QB'(1) << F)) ? (QB'(1) << F) : q;
		v = (F+2)'(m);
		if (zero)
			return '0;
		return neg ? -v : v;
	endfunction

	logic signed [IW-1:0] vin [3];
	logic                 in_zero;
	logic [2:0]           in_neg;

	assign vin[0]  = in_x;
	assign vin[1]  = in_y;
	assign vin[2]  = in_z;
	assign in_zero = (in_x == '0) && (in_y == '0) && (in_z == '0);
	assign in_neg  = {in_z[IW-1], in_y[IW-1], in_x[IW-1]};

	// valid and sideband delay line
	logic [LAT-2:0] vld_s;
	logic [DW-1:0]  dly_s [LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			out_vld <= 1'b0;
		end else begin
			vld_s   <= {vld_s[LAT-3:0], in_vld};
			out_vld <= vld_s[LAT-2];
		end
	end

	always_ff @(posedge clk) begin
		dly_s[0] <= {in_zero, in_neg, in_side};
		for (int k = 1; k < LAT - 1; k++)
			dly_s[k] <= dly_s[k-1];
	end

	// stage 1: magnitudes
	logic [IW-1:0] mag_s1 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			mag_s1[i] <= vin[i][IW-1] ? IW'(-vin[i]) : IW'(vin[i]);
	end

	// stage 2: leading one of the largest magnitude (same as of the OR)
	logic [IW-1:0] orv;
	logic [PW-1:0] lead;
	logic [PW-1:0] lead_s2;
	logic [IW-1:0] mag_s2 [3];

	always_comb begin
		orv  = mag_s1[0] | mag_s1[1] | mag_s1[2];
		lead = '0;
		for (int b = 0; b < IW; b++)
			if (orv[b])
				lead = PW'(b);
	end

	always_ff @(posedge clk) begin
		lead_s2 <= lead;
		mag_s2  <= mag_s1;
	end

	// stage 3: common power-of-two scale
	logic [IW-1:0]     shv  [3];
	logic [NORM_W-1:0] u_s3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (int'(lead_s2) >= NORM_MSB)
				shv[i] = mag_s2[i] >> (lead_s2 - PW'(NORM_MSB));
			else
				shv[i] = mag_s2[i] << (PW'(NORM_MSB) - lead_s2);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			u_s3[i] <= shv[i][NORM_W-1:0];
	end

	// stage 4: squares
	logic [2*NORM_W-1:0] sq_s4 [3];
	logic [NORM_W-1:0]   u_s4  [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			sq_s4[i] <= (2*NORM_W)'(u_s3[i]) * (2*NORM_W)'(u_s3[i]);
		u_s4 <= u_s3;
	end

	// stage 5: sum of squares, then square root stages
	logic [SUM_W-1:0]  rt_rem_s [RS+1];
	logic [SUM_W-1:0]  rt_res_s [RS+1];
	logic [NORM_W-1:0] rt_u_s   [RS+1][3];

	always_ff @(posedge clk) begin
		rt_rem_s[0] <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
		rt_res_s[0] <= '0;
		rt_u_s[0]   <= u_s4;
		for (int k = 0; k < RS; k++) begin
			{rt_rem_s[k+1], rt_res_s[k+1]} <= sqrt_pair(rt_rem_s[k], rt_res_s[k], k);
			rt_u_s[k+1] <= rt_u_s[k];
		end
	end

	// rounded numerator, then divider stages
	logic [NW-1:0]     dv_rem_s [DS+1][3];
	logic [QB-1:0]     dv_q_s   [DS+1][3];
	logic [NORM_W:0]   dv_n_s   [DS+1];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= (NW'(rt_u_s[RS][i]) << F) + NW'(rt_res_s[RS][NORM_W:1]);
			dv_q_s[0][i]   <= '0;
		end
		dv_n_s[0] <= rt_res_s[RS][NORM_W:0];
		for (int k = 0; k < DS; k++) begin
			for (int i = 0; i < 3; i++)
				{dv_rem_s[k+1][i], dv_q_s[k+1][i]} <=
					div_pair(dv_rem_s[k][i], dv_q_s[k][i], dv_n_s[k], k);
			dv_n_s[k+1] <= dv_n_s[k];
		end
	end

	// output register
	logic [DW-1:0] fl;
	assign fl = dly_s[LAT-2];

	always_ff @(posedge clk) begin
		out_x    <= finish(dv_q_s[DS][0], fl[SW],   fl[SW+3]);
		out_y    <= finish(dv_q_s[DS][1], fl[SW+1], fl[SW+3]);
		out_z    <= finish(dv_q_s[DS][2], fl[SW+2], fl[SW+3]);
		out_side <= fl[SW-1:0];
	end

endmodule
`default_nettype wire

[hw/rtl/look_at_view_matrix_core.sv]
// Top level: look-at view matrix pipeline, three rows per request.
`default_nettype none
// A new request is taken on every cycle that start is high; busy never rises.
// Each result appears on the row ports for one cycle, flagged by done; results
// come out in request order and cannot be held off. The path runs through the
// two normalizers in series, each with a 16-stage square root and a
// two-quotient-bits-per-stage divider.
module look_at_view_matrix_core
	import lav_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [31:0]        eye_x,
	input  logic signed [31:0]        eye_y,
	input  logic signed [31:0]        eye_z,
	input  logic signed [31:0]        target_x,
	input  logic signed [31:0]        target_y,
	input  logic signed [31:0]        target_z,
	input  logic signed [31:0]        up_x,
	input  logic signed [31:0]        up_y,
	input  logic signed [31:0]        up_z,
	output logic                      done,
	output logic signed [FRAC_BITS+1:0] side_x,
	output logic signed [FRAC_BITS+1:0] side_y,
	output logic signed [FRAC_BITS+1:0] side_z,
	output logic signed [31:0]        side_shift,
	output logic signed [FRAC_BITS+1:0] upward_x,
	output logic signed [FRAC_BITS+1:0] upward_y,
	output logic signed [FRAC_BITS+1:0] upward_z,
	output logic signed [31:0]        upward_shift,
	output logic signed [FRAC_BITS+1:0] forward_x,
	output logic signed [FRAC_BITS+1:0] forward_y,
	output logic signed [FRAC_BITS+1:0] forward_z,
	output logic signed [31:0]        forward_shift
);

	localparam int AW   = FRAC_BITS + 2;
	localparam int DW   = COORD_W + 1;
	localparam int PRW  = COORD_W + AW;
	localparam int CW   = PRW + 1;
	localparam int XW   = 2 * AW;
	localparam int DPW  = COORD_W + AW;
	localparam int DSW  = DPW + 2;
	localparam int RW   = (DSW > XW + 1) ? DSW : XW + 1;
	localparam int NLAT = 7 + SQRT_ITERS / SQRT_PER_STAGE
		+ (FRAC_BITS + DIV_PER_STAGE) / DIV_PER_STAGE;
	localparam int TLAT = 8 + 2 * NLAT;
	localparam int S1W  = 6 * COORD_W;
	localparam int S2W  = 3 * COORD_W + 3 * AW;

	localparam logic signed [RW-1:0] UNIT   = RW'(1) << FRAC_BITS;
	localparam logic signed [RW-1:0] SAT_HI = RW'(32'sh7fffffff);
	localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

	// divide by 2^FRAC_BITS, rounding half away from zero
	function automatic logic signed [RW-1:0] round_frac(input logic signed [RW-1:0] x);
		logic [RW-1:0] m;
		logic [RW-1:0] r;
		m = x[RW-1] ? RW'(-x) : RW'(x);
		r = (m + (RW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return x[RW-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [AW-1:0] cap_unit(input logic signed [RW-1:0] x);
		if (x > UNIT)
			return AW'(UNIT);
		if (x < -UNIT)
			return AW'(-UNIT);
		return AW'(x);
	endfunction

	function automatic logic signed [31:0] sat_word(input logic signed [RW-1:0] x);
		if (x > SAT_HI)
			return 32'(SAT_HI);
		if (x < SAT_LO)
			return 32'(SAT_LO);
		return 32'(x);
	endfunction

	assign busy = 1'b0;

	// valid chain outside the normalizers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic n1_vld, n2_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= n1_vld;
			v_s3 <= v_s2;
			v_s4 <= n2_vld;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			done <= v_s7;
		end
	end

	// stage 1: eye minus target
	logic signed [DW-1:0] d_s1   [3];
	coord_t               eye_s1 [3];
	coord_t               up_s1  [3];

	always_ff @(posedge clk) begin
		d_s1[0]   <= DW'(eye_x) - DW'(target_x);
		d_s1[1]   <= DW'(eye_y) - DW'(target_y);
		d_s1[2]   <= DW'(eye_z) - DW'(target_z);
		eye_s1[0] <= eye_x;
		eye_s1[1] <= eye_y;
		eye_s1[2] <= eye_z;
		up_s1[0]  <= up_x;
		up_s1[1]  <= up_y;
		up_s1[2]  <= up_z;
	end

	// forward axis
	logic [S1W-1:0]       n1_side_in, n1_side;
	logic signed [AW-1:0] fwd_a [3];
	coord_t               eye_a [3];
	coord_t               up_a  [3];

	assign n1_side_in = {up_s1[2], up_s1[1], up_s1[0], eye_s1[2], eye_s1[1], eye_s1[0]};

	lav_norm #(.IW(DW), .F(FRAC_BITS), .SW(S1W)) u_norm_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s1),
		.in_x     (d_s1[0]),
		.in_y     (d_s1[1]),
		.in_z     (d_s1[2]),
		.in_side  (n1_side_in),
		.out_vld  (n1_vld),
		.out_x    (fwd_a[0]),
		.out_y    (fwd_a[1]),
		.out_z    (fwd_a[2]),
		.out_side (n1_side)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			eye_a[i] = n1_side[i*COORD_W +: COORD_W];
			up_a[i]  = n1_side[(3+i)*COORD_W +: COORD_W];
		end
	end

	// stage 2: partial products of up x forward
	logic signed [PRW-1:0] pr_s2  [6];
	coord_t                eye_s2 [3];
	logic signed [AW-1:0]  fwd_s2 [3];

	always_ff @(posedge clk) begin
		pr_s2[0] <= PRW'(up_a[1]) * PRW'(fwd_a[2]);
		pr_s2[1] <= PRW'(up_a[2]) * PRW'(fwd_a[1]);
		pr_s2[2] <= PRW'(up_a[2]) * PRW'(fwd_a[0]);
		pr_s2[3] <= PRW'(up_a[0]) * PRW'(fwd_a[2]);
		pr_s2[4] <= PRW'(up_a[0]) * PRW'(fwd_a[1]);
		pr_s2[5] <= PRW'(up_a[1]) * PRW'(fwd_a[0]);
		eye_s2   <= eye_a;
		fwd_s2   <= fwd_a;
	end

	// stage 3: exact cross product
	logic signed [CW-1:0] c_s3   [3];
	coord_t               eye_s3 [3];
	logic signed [AW-1:0] fwd_s3 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			c_s3[i] <= CW'(pr_s2[2*i]) - CW'(pr_s2[2*i+1]);
		eye_s3 <= eye_s2;
		fwd_s3 <= fwd_s2;
	end

	// side axis
	logic [S2W-1:0]       n2_side_in, n2_side;
	logic signed [AW-1:0] side_b [3];
	logic signed [AW-1:0] fwd_b  [3];
	coord_t               eye_b  [3];

	assign n2_side_in = {fwd_s3[2], fwd_s3[1], fwd_s3[0], eye_s3[2], eye_s3[1], eye_s3[0]};

	lav_norm #(.IW(CW), .F(FRAC_BITS), .SW(S2W)) u_norm_side (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s3),
		.in_x     (c_s3[0]),
		.in_y     (c_s3[1]),
		.in_z     (c_s3[2]),
		.in_side  (n2_side_in),
		.out_vld  (n2_vld),
		.out_x    (side_b[0]),
		.out_y    (side_b[1]),
		.out_z    (side_b[2]),
		.out_side (n2_side)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			eye_b[i] = n2_side[i*COORD_W +: COORD_W];
			fwd_b[i] = n2_side[3*COORD_W + i*AW +: AW];
		end
	end

	// stage 4: partial products of forward x side
	logic signed [XW-1:0] fp_s4   [6];
	coord_t               eye_s4  [3];
	logic signed [AW-1:0] fwd_s4  [3];
	logic signed [AW-1:0] side_s4 [3];

	always_ff @(posedge clk) begin
		fp_s4[0] <= XW'(fwd_b[1]) * XW'(side_b[2]);
		fp_s4[1] <= XW'(fwd_b[2]) * XW'(side_b[1]);
		fp_s4[2] <= XW'(fwd_b[2]) * XW'(side_b[0]);
		fp_s4[3] <= XW'(fwd_b[0]) * XW'(side_b[2]);
		fp_s4[4] <= XW'(fwd_b[0]) * XW'(side_b[1]);
		fp_s4[5] <= XW'(fwd_b[1]) * XW'(side_b[0]);
		eye_s4   <= eye_b;
		fwd_s4   <= fwd_b;
		side_s4  <= side_b;
	end

	// stage 5: true up axis, rounded and capped; axes gathered per row
	logic signed [AW-1:0] ax_s5  [3][3];
	coord_t               eye_s5 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ax_s5[0][i] <= side_s4[i];
			ax_s5[1][i] <= cap_unit(round_frac(RW'(fp_s4[2*i]) - RW'(fp_s4[2*i+1])));
			ax_s5[2][i] <= fwd_s4[i];
		end
		eye_s5 <= eye_s4;
	end

	// stage 6: axis times eye products
	logic signed [DPW-1:0] dp_s6 [3][3];
	logic signed [AW-1:0]  ax_s6 [3][3];

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++)
			for (int i = 0; i < 3; i++)
				dp_s6[a][i] <= DPW'(ax_s5[a][i]) * DPW'(eye_s5[i]);
		ax_s6 <= ax_s5;
	end

	// stage 7: dot products
	logic signed [DSW-1:0] dsum_s7 [3];
	logic signed [AW-1:0]  ax_s7   [3][3];

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++)
			dsum_s7[a] <= DSW'(dp_s6[a][0]) + DSW'(dp_s6[a][1]) + DSW'(dp_s6[a][2]);
		ax_s7 <= ax_s6;
	end

	// output registers: negated, rounded, saturated translations
	always_ff @(posedge clk) begin
		side_x        <= ax_s7[0][0];
		side_y        <= ax_s7[0][1];
		side_z        <= ax_s7[0][2];
		side_shift    <= sat_word(-round_frac(RW'(dsum_s7[0])));
		upward_x      <= ax_s7[1][0];
		upward_y      <= ax_s7[1][1];
		upward_z      <= ax_s7[1][2];
		upward_shift  <= sat_word(-round_frac(RW'(dsum_s7[1])));
		forward_x     <= ax_s7[2][0];
		forward_y     <= ax_s7[2][1];
		forward_z     <= ax_s7[2][2];
		forward_shift <= sat_word(-round_frac(RW'(dsum_s7[2])));
	end

`ifndef SYNTHESIS
	localparam logic signed [AW-1:0] AX_ONE = AW'(1) << FRAC_BITS;

	// every result traces back to a request a fixed latency earlier
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, TLAT))
		else $error("result without matching request");

	// diagonal axis terms (side_x, upward_y, forward_z) stay within unit magnitude
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (side_x <= AX_ONE && side_x >= -AX_ONE
			&& upward_y <= AX_ONE && upward_y >= -AX_ONE
			&& forward_z <= AX_ONE && forward_z >= -AX_ONE))
		else $error("axis term out of unit range");

	// degenerate view direction zeroes the whole matrix
	a_zero_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(done && forward_x == '0 && forward_y == '0 && forward_z == '0)
		|-> (side_x == '0 && side_y == '0 && side_z == '0
			&& side_shift == '0 && upward_shift == '0 && forward_shift == '0))
		else $error("zero forward axis with nonzero row");

	// no side axis means no up axis
	a_zero_side: assert property (@(posedge clk) disable iff (!arst_n)
		(done && side_x == '0 && side_y == '0 && side_z == '0)
		|-> (upward_x == '0 && upward_y == '0 && upward_z == '0 && upward_shift == '0))
		else $error("zero side axis with nonzero up row");
`endif

endmodule
`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for look_at_view_matrix_core: random and directed camera requests.
module testbench;
	import lav_pkg::*;

	typedef longint vec3_t [3];

	typedef struct {
		coord_t eye [3];
		coord_t tgt [3];
		coord_t upv [3];
		int     gap;
		bit     drain;
	} camera_t;

	typedef struct {
		logic signed [17:0] ax [3][3];
		logic signed [31:0] sh [3];
	} rows_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	coord_t eye_x = '0, eye_y = '0, eye_z = '0;
	coord_t target_x = '0, target_y = '0, target_z = '0;
	coord_t up_x = '0, up_y = '0, up_z = '0;
	logic signed [17:0] side_x, side_y, side_z, upward_x, upward_y, upward_z;
	logic signed [17:0] forward_x, forward_y, forward_z;
	logic signed [31:0] side_shift, upward_shift, forward_shift;

	camera_t pending_cams [$];
	rows_t   matrix_rows [$];
	camera_t cur_cam;
	int      gap_left = 0;
	int      errors = 0;

	look_at_view_matrix_core dut (
		.clk, .arst_n, .start, .busy,
		.eye_x, .eye_y, .eye_z, .target_x, .target_y, .target_z,
		.up_x, .up_y, .up_z, .done,
		.side_x, .side_y, .side_z, .side_shift,
		.upward_x, .upward_y, .upward_z, .upward_shift,
		.forward_x, .forward_y, .forward_z, .forward_shift
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- predictor ----------------
	function automatic longint unsigned magnitude(longint x);
		return x < 0 ? -x : x;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// round away the fraction bits, half away from zero
	function automatic longint round_q(longint x);
		longint unsigned r;
		r = (magnitude(x) + (64'd1 << 15)) >> 16;
		return x < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clamp_unit(longint x);
		if (x > 65536) return 65536;
		if (x < -65536) return -65536;
		return x;
	endfunction

	function automatic vec3_t unit_axis(vec3_t v);
		vec3_t o;
		longint unsigned u [3];
		longint unsigned m, total, n, q;
		int lsh, rsh;
		lsh = 0;
		rsh = 0;
		for (int i = 0; i < 3; i++) u[i] = magnitude(v[i]);
		m = u[0];
		if (u[1] > m) m = u[1];
		if (u[2] > m) m = u[2];
		if (m == 0) begin
			o = '{0, 0, 0};
			return o;
		end
		while (m < (64'd1 << 30)) begin m <<= 1; lsh++; end
		while (m >= (64'd1 << 31)) begin m >>= 1; rsh++; end
		total = 0;
		for (int i = 0; i < 3; i++) begin
			u[i] = (u[i] << lsh) >> rsh;
			total += u[i] * u[i];
		end
		n = floor_sqrt(total);
		for (int i = 0; i < 3; i++) begin
			q = ((u[i] << 16) + (n >> 1)) / n;
			o[i] = clamp_unit(v[i] < 0 ? -longint'(q) : longint'(q));
		end
		return o;
	endfunction

	function automatic vec3_t cross3(vec3_t a, vec3_t b);
		vec3_t o;
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
		return o;
	endfunction

	function automatic logic signed [31:0] translation(vec3_t ax, vec3_t e);
		longint r;
		r = -round_q(ax[0] * e[0] + ax[1] * e[1] + ax[2] * e[2]);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic rows_t view_rows(camera_t c);
		rows_t r;
		vec3_t e, u, dir, fwd, sd, upw, tmp;
		vec3_t axes [3];
		for (int i = 0; i < 3; i++) begin
			e[i] = c.eye[i];
			u[i] = c.upv[i];
			dir[i] = longint'(c.eye[i]) - longint'(c.tgt[i]);
		end
		fwd = unit_axis(dir);
		sd = unit_axis(cross3(u, fwd));
		tmp = cross3(fwd, sd);
		for (int i = 0; i < 3; i++) upw[i] = clamp_unit(round_q(tmp[i]));
		axes[0] = sd;
		axes[1] = upw;
		axes[2] = fwd;
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) r.ax[k][i] = axes[k][i][17:0];
			r.sh[k] = translation(axes[k], e);
		end
		return r;
	endfunction

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		logic next_start;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			next_start = 1'b0;
			if (start && !busy) matrix_rows.push_back(view_rows(cur_cam));
			if (start && busy) begin
				next_start = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending_cams.size() > 0 &&
			    !(pending_cams[0].drain && matrix_rows.size() > 0)) begin
				cur_cam = pending_cams.pop_front();
				gap_left = cur_cam.gap;
				next_start = 1'b1;
				eye_x <= cur_cam.eye[0];
				eye_y <= cur_cam.eye[1];
				eye_z <= cur_cam.eye[2];
				target_x <= cur_cam.tgt[0];
				target_y <= cur_cam.tgt[1];
				target_z <= cur_cam.tgt[2];
				up_x <= cur_cam.upv[0];
				up_y <= cur_cam.upv[1];
				up_z <= cur_cam.upv[2];
			end
			start <= next_start;
		end
	end

	// ---------------- monitor ----------------
	task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
		if (got !== want) begin
			errors++;
			$display("mismatch %s: got %0d expected %0d", what, got, want);
		end
	endtask

	always @(posedge clk) begin
		rows_t w;
		if (arst_n && done) begin
			if (matrix_rows.size() == 0) begin
				errors++;
				$display("unexpected result at %0t", $time);
			end else begin
				w = matrix_rows.pop_front();
				report("side_x", side_x, w.ax[0][0]);
				report("side_y", side_y, w.ax[0][1]);
				report("side_z", side_z, w.ax[0][2]);
				report("side_shift", side_shift, w.sh[0]);
				report("upward_x", upward_x, w.ax[1][0]);
				report("upward_y", upward_y, w.ax[1][1]);
				report("upward_z", upward_z, w.ax[1][2]);
				report("upward_shift", upward_shift, w.sh[1]);
				report("forward_x", forward_x, w.ax[2][0]);
				report("forward_y", forward_y, w.ax[2][1]);
				report("forward_z", forward_z, w.ax[2][2]);
				report("forward_shift", forward_shift, w.sh[2]);
			end
		end
	end

	// ---------------- stimulus ----------------
	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'(int'($urandom_range(0, 200 << 16)) - (100 << 16));
			2: return coord_t'(int'($urandom_range(0, 64)) - 32);
			default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	function automatic int rand_gap(bit quiet);
		int p;
		if (quiet) return 0;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic add_cam(coord_t e0, coord_t e1, coord_t e2, coord_t t0, coord_t t1,
	    coord_t t2, coord_t u0, coord_t u1, coord_t u2, int gap, bit drain);
		camera_t c;
		c.eye = '{e0, e1, e2};
		c.tgt = '{t0, t1, t2};
		c.upv = '{u0, u1, u2};
		c.gap = gap;
		c.drain = drain;
		pending_cams.push_back(c);
	endtask

	localparam coord_t ONE = 32'sh00010000;
	localparam coord_t MAXC = 32'sh7fffffff;
	localparam coord_t MINC = 32'sh80000000;

	initial begin
		camera_t c;
		int m, kind;
		bit quiet;
		// directed: usual camera, eye on target, degenerate up, extremes
		add_cam(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0, 0, 0);
		add_cam(3 * ONE, 2 * ONE, 1 * ONE, 0, 0, 0, 0, ONE, 0, 0, 0);
		add_cam(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0, 0, 0);
		add_cam(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_cam(0, 4 * ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 0);
		add_cam(2 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_cam(0, 3 * ONE, 0, 0, ONE, 0, 0, -7 * ONE, 0, 0, 0);
		add_cam(MAXC, MAXC, MAXC, MINC, MINC, MINC, 0, ONE, 0, 0, 0);
		add_cam(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MAXC, 0, 0);
		add_cam(MAXC, MINC, MAXC, 0, 0, 0, MINC, MINC, MINC, 0, 0);
		add_cam(MAXC, 0, MINC, MINC, 0, MAXC, 0, MAXC, 0, 0, 0);
		add_cam(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 0, 0, 0, 0);
		add_cam(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
		add_cam(-1, -1, -1, 0, 0, 0, 1, 0, 0, 0, 0);
		add_cam(MAXC, 3 * ONE, -5 * ONE, 0, 0, 0, ONE, ONE, ONE, 0, 0);
		add_cam(32'sh40000000, 32'sh40000000, 0, 0, 0, 0, 0, 0, MAXC, 0, 0);
		add_cam(0, 0, -ONE, 0, 0, ONE, ONE, 0, 0, 0, 0);
		add_cam(-3 * ONE, 0, 0, 0, 0, 0, 0, ONE, ONE, 20, 1);
		// random: mostly proper cameras, some degenerate and raw-bit noise
		for (int n = 0; n < 650; n++) begin
			if (n % 100 == 0) quiet = $urandom_range(0, 2) == 0;
			kind = $urandom_range(0, 99);
			m = kind < 30 ? 0 : (kind < 80 ? 1 : (kind < 95 ? 2 : 3));
			for (int i = 0; i < 3; i++) begin
				c.eye[i] = rand_coord(m);
				c.tgt[i] = rand_coord(m);
				c.upv[i] = rand_coord($urandom_range(0, 3) == 0 ? 0 : 1);
			end
			kind = $urandom_range(0, 19);
			if (kind == 0) c.tgt = c.eye;
			if (kind == 1) begin
				// up along the view direction, scaled
				for (int i = 0; i < 3; i++)
					c.upv[i] = (c.eye[i] - c.tgt[i]) >>> $urandom_range(0, 8);
			end
			if (kind == 2) c.upv = '{0, 0, 0};
			c.gap = rand_gap(quiet);
			c.drain = (n == 300) || (n == 500);
			pending_cams.push_back(c);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_cams.size() == 0 && !start && matrix_rows.size() == 0);
		repeat (120) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
